>>> src/ipv6_text_address_parser_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPV6TP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ipv6tp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPV6TP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ipv6tp: next-cycle check failed");

`endif

>>> src/ipv6tp_pkg.sv
package ipv6tp_pkg;

	localparam int unsigned NumGroups = 8;
	localparam int unsigned GroupW    = 16;
	localparam logic [7:0]  ColonChar = 8'h3A;

	typedef logic [GroupW-1:0] group_t;

	// One character of address text
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} item_t;

	// One parsed address
	typedef struct packed {
		logic        ok;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
	} result_t;

	// Decode a hex digit: bit 4 marks a valid digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

>>> src/ipv6tp_in_stage.sv
module ipv6tp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ipv6tp_pkg::item_t   in_item,
	input  logic                advance,
	output logic                valid_s1,
	output ipv6tp_pkg::item_t   item_s1
);
	import ipv6tp_pkg::*;

	// Take a new word whenever the held one leaves or none is held
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload until it advances
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> src/ipv6tp_core.sv
module ipv6tp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ipv6tp_pkg::item_t     item,
	output ipv6tp_pkg::result_t   result
);
	import ipv6tp_pkg::*;

	// Parse state of the current text
	logic [3:0]  group_count_q, gap_position_q;
	logic        gap_seen_q, has_digit_q, overflow_q, prev_colon_q, at_start_q, failed_q;
	group_t      piece_q;
	group_t      head_q [NumGroups];
	group_t      tail_q [NumGroups];

	logic [3:0]  n_count, n_gpos, gp, after_cnt;
	logic        n_gap, n_digit, n_ovf, n_colon, n_start, n_failed;
	group_t      n_piece;
	logic [4:0]  hex;
	logic        colon_close, do_close, head_wr, tail_push, ok;
	group_t      close_val;
	group_t      head_n [NumGroups];
	group_t      tail_n [NumGroups];
	logic [63:0] hi, lo;

	// Step the parse state by one character
	always_comb begin
		n_count     = group_count_q;
		n_gpos      = gap_position_q;
		n_gap       = gap_seen_q;
		n_piece     = piece_q;
		n_digit     = has_digit_q;
		n_ovf       = overflow_q;
		n_colon     = prev_colon_q;
		n_start     = at_start_q;
		n_failed    = failed_q;
		colon_close = 1'b0;
		head_wr     = 1'b0;
		tail_push   = 1'b0;
		close_val   = piece_q;
		hex         = hex_value(item.ch);

		if (item.ch == ColonChar) begin
			if (at_start_q) begin
				n_start = 1'b0;
			end else if (prev_colon_q) begin
				if (gap_seen_q) begin
					n_failed = 1'b1;
				end else begin
					n_gap  = 1'b1;
					n_gpos = group_count_q;
				end
			end else begin
				colon_close = 1'b1;
			end
			n_colon = 1'b1;
		end else if (hex[4]) begin
			// a digit right after a lone leading colon
			if (prev_colon_q && group_count_q == 4'd0 && !gap_seen_q) begin
				n_failed = 1'b1;
			end
			if (piece_q[15:12] != 4'd0) begin
				n_ovf = 1'b1;
			end
			n_piece = {piece_q[11:0], hex[3:0]};
			n_digit = 1'b1;
			n_colon = 1'b0;
			n_start = 1'b0;
		end else begin
			n_failed = 1'b1;
			n_colon  = 1'b0;
			n_start  = 1'b0;
		end

		// Close the current group on a colon or at the end of the text
		do_close  = colon_close || (item.last && !n_colon);
		close_val = n_piece;
		if (do_close) begin
			if (!n_digit || n_ovf) begin
				n_failed = 1'b1;
			end else if (!n_count[3]) begin
				head_wr   = !n_gap;
				tail_push = n_gap;
				n_count   = n_count + 4'd1;
			end else begin
				n_failed = 1'b1;
			end
			n_piece = '0;
			n_digit = 1'b0;
			n_ovf   = 1'b0;
		end

		// A trailing colon is only valid as the end of a gap
		if (item.last && n_colon && !(n_gap && n_gpos == n_count)) begin
			n_failed = 1'b1;
		end
	end

	// Group stores as they stand after this character
	always_comb begin
		for (int i = 0; i < NumGroups; i++) begin
			head_n[i] = (head_wr && group_count_q[2:0] == 3'(i)) ? close_val : head_q[i];
			if (tail_push) begin
				tail_n[i] = (i == NumGroups - 1) ? close_val : tail_q[(i + 1) % NumGroups];
			end else begin
				tail_n[i] = tail_q[i];
			end
		end
	end

	// Place explicit groups around the zero run
	always_comb begin
		ok        = !n_failed && (n_gap ? !n_count[3] : n_count == 4'd8);
		gp        = n_gap ? n_gpos : 4'd8;
		after_cnt = n_count - n_gpos;
		hi        = '0;
		lo        = '0;
		for (int i = 0; i < NumGroups; i++) begin
			group_t g;
			if (4'(i) < gp) begin
				g = head_n[i];
			end else if (4'(i) + after_cnt >= 4'd8) begin
				g = tail_n[i];
			end else begin
				g = '0;
			end
			if (i < 4) begin
				hi[(3 - i) * GroupW +: GroupW] = g;
			end else begin
				lo[(7 - i) * GroupW +: GroupW] = g;
			end
		end
		result.ok        = ok;
		result.addr_high = ok ? hi : 64'd0;
		result.addr_low  = ok ? lo : 64'd0;
	end

	// Advance control state; clear it after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q  <= '0;
			gap_position_q <= '0;
			gap_seen_q     <= 1'b0;
			piece_q        <= '0;
			has_digit_q    <= 1'b0;
			overflow_q     <= 1'b0;
			prev_colon_q   <= 1'b0;
			at_start_q     <= 1'b1;
			failed_q       <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				group_count_q  <= '0;
				gap_position_q <= '0;
				gap_seen_q     <= 1'b0;
				piece_q        <= '0;
				has_digit_q    <= 1'b0;
				overflow_q     <= 1'b0;
				prev_colon_q   <= 1'b0;
				at_start_q     <= 1'b1;
				failed_q       <= 1'b0;
			end else begin
				group_count_q  <= n_count;
				gap_position_q <= n_gpos;
				gap_seen_q     <= n_gap;
				piece_q        <= n_piece;
				has_digit_q    <= n_digit;
				overflow_q     <= n_ovf;
				prev_colon_q   <= n_colon;
				at_start_q     <= n_start;
				failed_q       <= n_failed;
			end
		end
	end

	// Group stores hold payload only
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < NumGroups; i++) begin
				head_q[i] <= head_n[i];
				tail_q[i] <= tail_n[i];
			end
		end
	end

endmodule

>>> src/ipv6tp_out_reg.sv
module ipv6tp_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ipv6tp_pkg::result_t   result,
	output logic                  slot_free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ipv6tp_pkg::result_t   out_result
);
	import ipv6tp_pkg::*;

	logic valid_q;

	// Slot is free when empty or being drained this cycle
	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_result <= result;
		end
	end

endmodule

>>> src/ipv6_text_address_parser.sv
// Flow: a character is registered in the input stage, then parsed; the result word
//   is registered in the output slot when the last character leaves the parse stage.
// Throughput: one character per cycle; a stalled result word stalls input
//   only when the next last character reaches the parse stage.
// Reset: arst_n clears all control state and drops m_tvalid; group stores are not reset.
`include "ipv6_text_address_parser_assert.svh"

module ipv6_text_address_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] ch
	input  logic         s_tlast,   // last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] addr_high, [127:64] addr_low
	output logic         m_tuser    // [0] ok
);
	import ipv6tp_pkg::*;

	item_t   in_item, item_s1;
	result_t step_result, out_result;
	logic    valid_s1, advance, slot_free, load;

	assign in_item.ch   = s_tdata;
	assign in_item.last = s_tlast;

	// Advance unless a last character waits on a full result slot
	assign advance = valid_s1 && (!item_s1.last || slot_free);
	assign load    = advance && item_s1.last;

	ipv6tp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ipv6tp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (step_result)
	);

	ipv6tp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.result     (step_result),
		.slot_free  (slot_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tuser = out_result.ok;
	assign m_tdata = {out_result.addr_low, out_result.addr_high};

	`IPV6TP_ASSERT_IMPLY(a_failed_is_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 128'd0)
	`IPV6TP_ASSERT_IMPLY(a_only_last_stalls, clk, arst_n, !s_tready, valid_s1 && item_s1.last)
	`IPV6TP_ASSERT_NEXT(a_last_gives_word, clk, arst_n, load, m_tvalid)

endmodule

>>> sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv6tp_pkg::*;

	localparam logic [7:0] DigitBase = "0";
	localparam logic [7:0] DigitTop  = "9";
	localparam logic [7:0] LowerBase = "a";
	localparam logic [7:0] LowerTop  = "f";
	localparam logic [7:0] UpperBase = "A";
	localparam logic [7:0] UpperTop  = "F";

	// Ways to damage a well-formed address text
	typedef enum int {
		MutNone,
		MutStrayChar,
		MutExtraColon,
		MutDropChar,
		MutExtraDigit,
		MutExtraGroup
	} mutation_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         m_tuser;

	// Stall control and bookkeeping
	bit      idle_on;
	int      ready_hold;
	int      error_count;
	int      chars_sent;
	result_t expected_addrs[$];

	// Parser state mirror
	group_t      grp_mem[NumGroups];
	logic [3:0]  n_groups;
	logic [3:0]  gap_at;
	bit          gap_open;
	logic [15:0] piece;
	bit          digit_seen;
	bit          piece_wide;
	bit          after_colon;
	bit          text_start;
	bit          text_bad;

	ipv6_text_address_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Hold off the result side in random bursts
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			ready_hold <= $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result word with the oldest predicted address
	always @(posedge clk) begin : check_port
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_addrs.size() == 0) begin
				$display("%0t: unexpected result word ok=%0b data=%h", $realtime,
					m_tuser, m_tdata);
				error_count++;
			end else begin
				want = expected_addrs.pop_front();
				if (m_tuser !== want.ok) begin
					$display("%0t: ok mismatch: expected %0b, actual %0b", $realtime,
						want.ok, m_tuser);
					error_count++;
				end
				if (m_tdata[63:0] !== want.addr_high) begin
					$display("%0t: addr_high mismatch: expected %h, actual %h", $realtime,
						want.addr_high, m_tdata[63:0]);
					error_count++;
				end
				if (m_tdata[127:64] !== want.addr_low) begin
					$display("%0t: addr_low mismatch: expected %h, actual %h", $realtime,
						want.addr_low, m_tdata[127:64]);
					error_count++;
				end
			end
		end
	end

	// Start a fresh text
	function automatic void clear_parse();
		n_groups = '0;
		gap_at = '0;
		gap_open = 1'b0;
		piece = '0;
		digit_seen = 1'b0;
		piece_wide = 1'b0;
		after_colon = 1'b0;
		text_start = 1'b1;
		text_bad = 1'b0;
	endfunction

	// Bit 4 flags a hex digit, bits 3:0 carry its value
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= DigitBase && c <= DigitTop)
			return {1'b1, 4'(c - DigitBase)};
		if (c >= LowerBase && c <= LowerTop)
			return {1'b1, 4'(c - LowerBase + 8'd10)};
		if (c >= UpperBase && c <= UpperTop)
			return {1'b1, 4'(c - UpperBase + 8'd10)};
		return 5'd0;
	endfunction

	// Store the finished group, or mark the text bad
	function automatic void end_group();
		if (!digit_seen || piece_wide) begin
			text_bad = 1'b1;
		end else if (n_groups < NumGroups) begin
			grp_mem[n_groups[2:0]] = piece;
			n_groups++;
		end else begin
			text_bad = 1'b1;
		end
		piece = '0;
		digit_seen = 1'b0;
		piece_wide = 1'b0;
	endfunction

	// Advance the parse by one character; on the final one queue the address
	function automatic void parse_char(input logic [7:0] c, input bit fin);
		logic [4:0]  dig;
		result_t     r;
		int          zeros;
		int          gp;
		logic [15:0] g;
		dig = nibble_of(c);
		if (c == ColonChar) begin
			if (text_start) begin
				text_start = 1'b0;
			end else if (after_colon) begin
				if (gap_open) begin
					text_bad = 1'b1;
				end else begin
					gap_open = 1'b1;
					gap_at = n_groups;
				end
			end else begin
				end_group();
			end
			after_colon = 1'b1;
		end else if (dig[4]) begin
			// a lone leading colon before the first digit
			if (after_colon && n_groups == 0 && !gap_open)
				text_bad = 1'b1;
			if (piece[15:12] != 0)
				piece_wide = 1'b1;
			piece = {piece[11:0], dig[3:0]};
			digit_seen = 1'b1;
			after_colon = 1'b0;
			text_start = 1'b0;
		end else begin
			text_bad = 1'b1;
			after_colon = 1'b0;
			text_start = 1'b0;
		end
		if (!fin)
			return;

		if (after_colon) begin
			if (!(gap_open && gap_at == n_groups))
				text_bad = 1'b1;
		end else begin
			end_group();
		end

		r.ok = !text_bad && (gap_open ? n_groups <= NumGroups - 1 : n_groups == NumGroups);
		r.addr_high = '0;
		r.addr_low = '0;
		if (r.ok) begin
			zeros = gap_open ? NumGroups - n_groups : 0;
			gp = gap_open ? int'(gap_at) : NumGroups;
			for (int i = 0; i < NumGroups; i++) begin
				if (i < gp)
					g = grp_mem[i];
				else if (i < gp + zeros)
					g = '0;
				else
					g = grp_mem[i - zeros];
				if (i < 4)
					r.addr_high = {r.addr_high[47:0], g};
				else
					r.addr_low = {r.addr_low[47:0], g};
			end
		end
		expected_addrs.push_back(r);
		clear_parse();
	endfunction

	// Offer one character and wait until it is taken
	task automatic send_char(input logic [7:0] c, input bit fin, input bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_sent++;
		parse_char(c, fin);
	endtask

	// Send a whole text; some texts run without source gaps
	task automatic send_text(input logic [7:0] txt[$]);
		bit gaps;
		gaps = idle_on && $urandom_range(0, 3) != 0;
		foreach (txt[i])
			send_char(txt[i], i == txt.size() - 1, gaps);
	endtask

	task automatic send_string(input string s);
		logic [7:0] txt[$];
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
		send_text(txt);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 10)
			return DigitBase + nib;
		return (upper ? UpperBase : LowerBase) + nib - 8'd10;
	endfunction

	// Append one hex group, with random leading zeros and letter case
	function automatic void put_group(ref logic [7:0] txt[$]);
		logic [15:0] v;
		int          need;
		int          ndig;
		case ($urandom_range(0, 3))
			0: v = 16'h0000;
			1: v = 16'hFFFF;
			default: v = 16'($urandom);
		endcase
		need = v > 16'h0FFF ? 4 : v > 16'h00FF ? 3 : v > 16'h000F ? 2 : 1;
		ndig = $urandom_range(need, 4);
		for (int j = ndig - 1; j >= 0; j--)
			txt.push_back(hex_char(4'(v >> (4 * j)), 1'($urandom_range(0, 1))));
	endfunction

	// Build a well-formed address, then damage some of them
	function automatic void build_address(ref logic [7:0] txt[$]);
		bit        use_gap;
		int        k;
		int        p;
		mutation_t mut;
		use_gap = 1'($urandom_range(0, 1));
		k = use_gap ? $urandom_range(0, NumGroups - 1) : NumGroups;
		p = use_gap ? $urandom_range(0, k) : k;
		for (int i = 0; i < k; i++) begin
			if (use_gap && i == p) begin
				txt.push_back(ColonChar);
				txt.push_back(ColonChar);
			end else if (i > 0) begin
				txt.push_back(ColonChar);
			end
			put_group(txt);
		end
		if (use_gap && p == k) begin
			txt.push_back(ColonChar);
			txt.push_back(ColonChar);
		end

		mut = $urandom_range(0, 9) < 7 ? MutNone : mutation_t'($urandom_range(1, 5));
		case (mut)
			MutStrayChar:
				txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
			MutExtraColon:
				txt.insert($urandom_range(0, txt.size()), ColonChar);
			MutDropChar:
				if (txt.size() > 1)
					txt.delete($urandom_range(0, txt.size() - 1));
			MutExtraDigit:
				txt.insert($urandom_range(0, txt.size()),
					hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
			MutExtraGroup: begin
				txt.push_back(ColonChar);
				put_group(txt);
			end
			default: ;
		endcase
	endfunction

	task automatic test_valid_forms();
		string cases[] = '{
			"1:2:3:4:5:6:7:8",
			"ffff:FFFF:fFfF:FfFf:ffff:FFFF:ffff:FFFF",
			"0:0:0:0:0:0:0:0",
			"::",
			"::1",
			"1::",
			"1:2:3:4:5:6:7::",
			"::2:3:4:5:6:7:8",
			"2001:0DB8::8a2e:0370:7334",
			"0000:0000:0000:0000:0000:0000:0000:0001"
		};
		foreach (cases[i])
			send_string(cases[i]);
	endtask

	task automatic test_malformed_texts();
		string cases[] = '{
			"1:2:3:4:5:6:7",
			"1:2:3:4:5:6:7:8:9",
			"1:2:3:4::5:6:7:8",
			"1:2:3:4:5:6:7:8::",
			"1::2::3",
			":::",
			"1:::2",
			":1:2:3:4:5:6:7:8",
			"1:2:3:4:5:6:7:8:",
			"10000::",
			"0x1::",
			"-1::",
			"::1 ",
			":",
			"a"
		};
		foreach (cases[i])
			send_string(cases[i]);
	endtask

	// Character codes at both ends of the byte range
	task automatic test_char_extremes();
		logic [7:0] txt[$];
		txt = {8'h00};
		send_text(txt);
		txt = {ColonChar, ColonChar, 8'hFF};
		send_text(txt);
	endtask

	task automatic test_random_addresses(input int budget);
		logic [7:0] txt[$];
		int         stop_at;
		stop_at = chars_sent + budget;
		while (chars_sent < stop_at) begin
			txt.delete();
			build_address(txt);
			if (txt.size() > 0)
				send_text(txt);
		end
	endtask

	// Short texts of colons, digits and arbitrary bytes
	task automatic test_noise_texts(input int budget);
		logic [7:0] txt[$];
		int         stop_at;
		int         len;
		stop_at = chars_sent + budget;
		while (chars_sent < stop_at) begin
			txt.delete();
			len = $urandom_range(1, 12);
			repeat (len) begin
				case ($urandom_range(0, 2))
					0: txt.push_back(ColonChar);
					1: txt.push_back(hex_char(4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1))));
					default: txt.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			send_text(txt);
		end
	endtask

	// Back-to-back addresses with both sides always ready
	task automatic test_steady_stream(input int budget);
		idle_on = 1'b0;
		test_random_addresses(budget);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		idle_on = 1'b1;
		ready_hold = 0;
		error_count = 0;
		chars_sent = 0;
		clear_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_forms();
		test_malformed_texts();
		test_char_extremes();
		test_random_addresses(550);
		test_noise_texts(100);
		test_steady_stream(250);

		// drain the result side, then allow for the pipeline depth
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_addrs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// About 1250 characters with worst-case gaps and stalls stay far below this
	initial begin
		#10_000_000;
		$display("%0t: timeout", $realtime);
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/ipv6tp_pkg.sv
src/ipv6tp_in_stage.sv
src/ipv6tp_core.sv
src/ipv6tp_out_reg.sv
src/ipv6_text_address_parser.sv
sim/tb_top.sv
